/* design/ahe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ahe_pkg;

  // Default tree size and path length limit.
  localparam int SYMBOL_COUNT   = 705;
  localparam int MAX_CODE_DEPTH = 50;

  // Fixed widths and reset value of the coder.
  localparam int COUNT_W          = 11;
  localparam int WORD_BITS        = 32;
  localparam int FREQ_LIMIT_RESET = 2000;
  localparam int APB_DATA_W       = 32;
  localparam int APB_ADDR_W       = 3;

  // Request actions.
  localparam logic [1:0] ACT_SYMBOL = 2'd0;
  localparam logic [1:0] ACT_RAW    = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  // Register index of the halving limit.
  localparam logic REG_FREQ_LIMIT = 1'b0;

  typedef struct packed {
    logic [1:0]  action;
    logic [13:0] value;
    logic [3:0]  bit_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] packed_word;
    logic        last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

/* design/ahe_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module ahe_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1410
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/adaptive_huffman_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Adaptive Huffman encoder with a 32-bit bit packer.
// Requests enter on the sym channel (valid/ready): action 0 codes a symbol,
// action 1 appends bit_count raw bits of value (LSB first), action 2 flushes
// the pending bits left-aligned into a final word. Packed words leave on the
// word channel (valid/ready); last_of_run marks the final word of a request.
// One request is worked on at a time. A symbol reads its path from its leaf
// up to the root, packs its code bits, then updates the tree, re-summing the
// counts up to the root after the increment and after every swap; all tree
// state lives in four single-port-read RAMs, so each step waits for its
// registered read. A halving pass over the counts runs when the root count
// reaches freq_limit. After reset the block writes the initial tree into the
// RAMs with sym_ready low; APB writes are taken throughout.
// A finished word sits in an output register; if the receiver stalls, the
// packer waits only when a further word is due, else it carries on.
module adaptive_huffman_encoder #(
  parameter int SYMBOL_COUNT   = ahe_pkg::SYMBOL_COUNT,
  parameter int MAX_CODE_DEPTH = ahe_pkg::MAX_CODE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              sym_valid,
  output logic                                   sym_ready,
  input  wire ahe_pkg::in_item_t                 sym_item,
  output logic                                   word_valid,
  input  wire logic                              word_ready,
  output ahe_pkg::out_item_t                     word_item,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ahe_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [ahe_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [ahe_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  localparam int NODE_TOTAL = 2 * SYMBOL_COUNT;
  localparam int NW         = $clog2(NODE_TOTAL);
  localparam int SW         = $clog2(SYMBOL_COUNT);
  localparam int CW         = ahe_pkg::COUNT_W;
  localparam int PW         = (MAX_CODE_DEPTH > 15) ? MAX_CODE_DEPTH : 15;
  localparam int PLW        = $clog2(PW + 1);
  localparam logic [NW-1:0] ROOT = NW'(1);
  localparam logic REG_FREQ_LIMIT_ADDR = ahe_pkg::REG_FREQ_LIMIT;

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_P0    = 5'd2;
  localparam logic [4:0] S_P1    = 5'd3;
  localparam logic [4:0] S_P2    = 5'd4;
  localparam logic [4:0] S_PUSH  = 5'd5;
  localparam logic [4:0] S_FLUSH = 5'd6;
  localparam logic [4:0] S_U0    = 5'd7;
  localparam logic [4:0] S_U1    = 5'd8;
  localparam logic [4:0] S_U2    = 5'd9;
  localparam logic [4:0] S_R0    = 5'd10;
  localparam logic [4:0] S_R1    = 5'd11;
  localparam logic [4:0] S_R2    = 5'd12;
  localparam logic [4:0] S_R3    = 5'd13;
  localparam logic [4:0] S_R4    = 5'd14;
  localparam logic [4:0] S_HALF  = 5'd15;
  localparam logic [4:0] S_L0    = 5'd16;
  localparam logic [4:0] S_L1    = 5'd17;
  localparam logic [4:0] S_L2    = 5'd18;
  localparam logic [4:0] S_L3    = 5'd19;
  localparam logic [4:0] S_L4    = 5'd20;
  localparam logic [4:0] S_L5    = 5'd21;
  localparam logic [4:0] S_L6    = 5'd22;
  localparam logic [4:0] S_L7    = 5'd23;
  localparam logic [4:0] S_L8    = 5'd24;

  logic [4:0]    state;
  logic [4:0]    resum_ret;
  logic [CW-1:0] freq_limit;

  // Working registers of the tree walk.
  logic [NW-1:0] x, p, a, b, up, top, ra, rb, lcu, rcu;
  logic          upleft, is_sym;
  logic [CW-1:0] ca;
  logic [NW-1:0] ini;
  logic [NW:0]   hr;
  logic [NW-1:0] h_wa;
  logic          h_pend;

  // Packer.
  logic [PW-1:0]  push_src;
  logic [PLW-1:0] plen;
  logic [31:0]    pend_bits;
  logic [4:0]     pend_cnt;

  // RAM ports.
  logic [NW-1:0] par_ra, cnt_ra, lc_ra, rc_ra;
  logic          par_we, cnt_we, lc_we, rc_we;
  logic [NW-1:0] par_wa, cnt_wa, lc_wa, rc_wa;
  logic [NW-1:0] par_wd, lc_wd, rc_wd;
  logic [CW-1:0] cnt_wd;
  logic [NW-1:0] par_raw, lc_raw, rc_raw;
  logic [CW-1:0] cnt_raw;
  logic          par_ok, cnt_ok, lc_ok, rc_ok;
  logic [NW-1:0] par_q, lc_q, rc_q;
  logic [CW-1:0] cnt_q;
  logic          lc_wok, rc_wok, pc_wok_p, pc_wok_c;

  logic          slot_free;
  logic          accept;
  logic [CW-1:0] sum;
  logic          full;
  logic [31:0]   nb;
  logic          bit_in;

  ahe_ram #(.WIDTH(NW), .DEPTH(NODE_TOTAL)) u_par (
    .clk(clk), .we(par_we && pc_wok_p), .waddr(par_wa), .wdata(par_wd),
    .raddr(par_ra), .rdata(par_raw)
  );
  ahe_ram #(.WIDTH(CW), .DEPTH(NODE_TOTAL)) u_cnt (
    .clk(clk), .we(cnt_we && pc_wok_c), .waddr(cnt_wa), .wdata(cnt_wd),
    .raddr(cnt_ra), .rdata(cnt_raw)
  );
  ahe_ram #(.WIDTH(NW), .DEPTH(SYMBOL_COUNT)) u_lc (
    .clk(clk), .we(lc_we && lc_wok), .waddr(lc_wa[SW-1:0]), .wdata(lc_wd),
    .raddr(lc_ra[SW-1:0]), .rdata(lc_raw)
  );
  ahe_ram #(.WIDTH(NW), .DEPTH(SYMBOL_COUNT)) u_rc (
    .clk(clk), .we(rc_we && rc_wok), .waddr(rc_wa[SW-1:0]), .wdata(rc_wd),
    .raddr(rc_ra[SW-1:0]), .rdata(rc_raw)
  );

  // Out-of-range reads return zero, out-of-range writes are dropped.
  assign lc_wok   = int'(lc_wa) < SYMBOL_COUNT;
  assign rc_wok   = int'(rc_wa) < SYMBOL_COUNT;
  assign pc_wok_p = int'(par_wa) < NODE_TOTAL;
  assign pc_wok_c = int'(cnt_wa) < NODE_TOTAL;
  assign par_q = par_ok ? par_raw : '0;
  assign cnt_q = cnt_ok ? cnt_raw : '0;
  assign lc_q  = lc_ok ? lc_raw : '0;
  assign rc_q  = rc_ok ? rc_raw : '0;

  always_ff @(posedge clk) begin
    par_ok <= int'(par_ra) < NODE_TOTAL;
    cnt_ok <= int'(cnt_ra) < NODE_TOTAL;
    lc_ok  <= int'(lc_ra) < SYMBOL_COUNT;
    rc_ok  <= int'(rc_ra) < SYMBOL_COUNT;
  end

  assign slot_free = !word_valid || word_ready;
  assign sym_ready = (state == S_IDLE);
  assign accept    = sym_valid && sym_ready;
  assign sum       = ca + cnt_q;
  assign full      = (pend_cnt == 5'd31);
  assign bit_in    = push_src[0];
  assign nb        = {pend_bits[30:0], bit_in};
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_FREQ_LIMIT_ADDR) ?
                     ahe_pkg::APB_DATA_W'(freq_limit) : '0;

  // RAM access for each step of the sequencer.
  always_comb begin
    par_ra = '0; cnt_ra = '0; lc_ra = '0; rc_ra = '0;
    par_we = 1'b0; cnt_we = 1'b0; lc_we = 1'b0; rc_we = 1'b0;
    par_wa = '0; cnt_wa = '0; lc_wa = '0; rc_wa = '0;
    par_wd = '0; cnt_wd = '0; lc_wd = '0; rc_wd = '0;
    case (state)
      S_INIT: begin
        par_we = 1'b1; par_wa = ini; par_wd = ini >> 1;
        cnt_we = 1'b1; cnt_wa = ini; cnt_wd = CW'(1);
        lc_we  = 1'b1; lc_wa = ini; lc_wd = {ini[NW-2:0], 1'b0};
        rc_we  = 1'b1; rc_wa = ini; rc_wd = {ini[NW-2:0], 1'b1};
      end
      S_P0: par_ra = x;
      S_P1: rc_ra = par_q;
      S_U0: begin
        cnt_ra = a; par_ra = a;
      end
      S_U1: begin
        cnt_we = 1'b1; cnt_wa = a; cnt_wd = cnt_q + CW'(1);
        lc_ra = par_q; rc_ra = par_q;
      end
      S_R0: begin
        cnt_ra = ra; par_ra = ra;
      end
      S_R1: cnt_ra = rb;
      S_R2: begin
        cnt_we = 1'b1; cnt_wa = p; cnt_wd = sum;
        par_ra = p;
      end
      S_R3: begin
        lc_ra = par_q; rc_ra = par_q;
      end
      S_HALF: begin
        cnt_we = h_pend; cnt_wa = h_wa; cnt_wd = cnt_q >> 1;
        cnt_ra = hr[NW-1:0];
      end
      S_L0: begin
        par_ra = up; lc_ra = up; rc_ra = up;
      end
      S_L1: begin
        lc_ra = par_q; rc_ra = par_q;
      end
      S_L2: cnt_ra = a;
      S_L3: cnt_ra = b;
      S_L4: begin
        if (ca > cnt_q) begin
          par_we = 1'b1; par_wa = b; par_wd = up;
          if (upleft) begin
            rc_we = 1'b1; rc_wa = top; rc_wd = a;
          end else begin
            lc_we = 1'b1; lc_wa = top; lc_wd = a;
          end
        end
      end
      S_L5: begin
        par_we = 1'b1; par_wa = a; par_wd = top;
        if (lcu == a) begin
          lc_we = 1'b1; lc_wa = up; lc_wd = b;
        end else begin
          rc_we = 1'b1; rc_wa = up; rc_wd = b;
        end
      end
      S_L6: par_ra = a;
      S_L7: par_ra = par_q;
      default: ;
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_limit <= CW'(ahe_pkg::FREQ_LIMIT_RESET);
    end else if (psel && penable && pwrite && paddr[2] == REG_FREQ_LIMIT_ADDR) begin
      freq_limit <= pwdata[CW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else begin
      if (state == S_PUSH && plen != '0 && full && slot_free) begin
        word_valid <= 1'b1;
        word_item.packed_word <= nb;
        word_item.last_of_run <= int'(plen) <= ahe_pkg::WORD_BITS;
      end else if (state == S_FLUSH && slot_free) begin
        word_valid <= 1'b1;
        word_item.packed_word <= pend_bits << (6'd32 - {1'b0, pend_cnt});
        word_item.last_of_run <= 1'b1;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ini       <= '0;
      pend_cnt  <= '0;
      pend_bits <= '0;
      resum_ret <= S_IDLE;
      h_pend    <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          ini <= ini + NW'(1);
          if (int'(ini) == NODE_TOTAL - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (sym_item.action)
              ahe_pkg::ACT_SYMBOL: begin
                if (int'(sym_item.value) < SYMBOL_COUNT) begin
                  x        <= NW'(32'(sym_item.value) + SYMBOL_COUNT);
                  a        <= NW'(32'(sym_item.value) + SYMBOL_COUNT);
                  push_src <= '0;
                  plen     <= '0;
                  is_sym   <= 1'b1;
                  state    <= S_P0;
                end
              end
              ahe_pkg::ACT_RAW: begin
                push_src <= PW'(sym_item.value);
                plen     <= PLW'(sym_item.bit_count);
                is_sym   <= 1'b0;
                state    <= S_PUSH;
              end
              ahe_pkg::ACT_FLUSH: begin
                if (pend_cnt != '0) begin
                  state <= S_FLUSH;
                end
              end
              default: ;
            endcase
          end
        end
        // Walk from the leaf to the root, collecting branch bits.
        S_P0: state <= S_P1;
        S_P1: begin
          p     <= par_q;
          state <= S_P2;
        end
        S_P2: begin
          if (int'(plen) < MAX_CODE_DEPTH) begin
            push_src <= {push_src[PW-2:0], (rc_q == x)};
            plen     <= plen + PLW'(1);
          end
          x     <= p;
          state <= (p == ROOT) ? S_PUSH : S_P0;
        end
        // Pack one bit a cycle, holding when a word is due and the slot is busy.
        S_PUSH: begin
          if (plen == '0) begin
            state <= is_sym ? S_U0 : S_IDLE;
          end else if (!full || slot_free) begin
            pend_bits <= nb;
            pend_cnt  <= full ? 5'd0 : pend_cnt + 5'd1;
            push_src  <= push_src >> 1;
            plen      <= plen - PLW'(1);
          end
        end
        S_FLUSH: begin
          if (slot_free) begin
            pend_cnt <= '0;
            state    <= S_IDLE;
          end
        end
        // Leaf increment, then the first re-sum unless the parent is the root.
        S_U0: state <= S_U1;
        S_U1: begin
          up    <= par_q;
          state <= (par_q == ROOT) ? S_IDLE : S_U2;
        end
        S_U2: begin
          rb        <= (lc_q == a) ? rc_q : lc_q;
          ra        <= a;
          resum_ret <= S_L0;
          state     <= S_R0;
        end
        // Re-sum counts from (ra, rb) up to the root.
        S_R0: state <= S_R1;
        S_R1: begin
          ca    <= cnt_q;
          p     <= par_q;
          state <= S_R2;
        end
        S_R2: begin
          ra <= p;
          if (p == ROOT) begin
            if (sum >= freq_limit) begin
              hr     <= (NW+1)'(1);
              h_pend <= 1'b0;
              state  <= S_HALF;
            end else begin
              state <= resum_ret;
            end
          end else begin
            state <= S_R3;
          end
        end
        S_R3: state <= S_R4;
        S_R4: begin
          rb    <= (lc_q == ra) ? rc_q : lc_q;
          state <= S_R0;
        end
        // Halve every count, read and write one entry apart.
        S_HALF: begin
          if (int'(hr) < NODE_TOTAL) begin
            h_pend <= 1'b1;
            h_wa   <= hr[NW-1:0];
            hr     <= hr + (NW+1)'(1);
          end else begin
            h_pend <= 1'b0;
            if (!h_pend) begin
              state <= resum_ret;
            end
          end
        end
        // Swap a node with its parent's sibling when it has outgrown it.
        S_L0: state <= S_L1;
        S_L1: begin
          top   <= par_q;
          lcu   <= lc_q;
          rcu   <= rc_q;
          state <= S_L2;
        end
        S_L2: begin
          upleft <= (lc_q == up);
          b      <= (lc_q == up) ? rc_q : lc_q;
          state  <= S_L3;
        end
        S_L3: begin
          ca    <= cnt_q;
          state <= S_L4;
        end
        S_L4: state <= (ca > cnt_q) ? S_L5 : S_L6;
        S_L5: begin
          ra        <= b;
          rb        <= (lcu == a) ? rcu : lcu;
          a         <= b;
          resum_ret <= S_L6;
          state     <= S_R0;
        end
        S_L6: state <= S_L7;
        S_L7: begin
          a     <= par_q;
          state <= S_L8;
        end
        S_L8: begin
          up    <= par_q;
          state <= (par_q == ROOT) ? S_IDLE : S_L0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/ahe_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the encoder.
module ahe_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic sym_valid,
  input wire logic sym_ready,
  input wire logic word_valid,
  input wire logic word_ready,
  input wire logic pready
);

  // A waiting word is not withdrawn.
  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_ready |=> word_valid)
    else $error("word withdrawn while stalled");

  // The tree is being written after reset, so no request is taken.
  a_init_busy: assert property (@(posedge clk)
    rst |=> !sym_ready)
    else $error("request taken during initialisation");

  // No word is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !word_valid)
    else $error("word offered after reset");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind adaptive_huffman_encoder ahe_checker u_ahe_checker (
  .clk(clk), .rst(rst), .sym_valid(sym_valid), .sym_ready(sym_ready),
  .word_valid(word_valid), .word_ready(word_ready), .pready(pready)
);

`default_nettype wire
